FILE: rtl/gbw_pkg.sv
// shared types and constants for the gaussian window blur
`timescale 1ns / 1ps
package gbw_pkg;

   // default build constants
   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int KERNEL_SIZE_DEF = 9;

   // configuration register widths and reset values
   localparam int CFG_W_W     = 11;
   localparam int CFG_H_W     = 12;
   localparam int TAP_W       = 16;
   localparam int NUM_TAPS    = 5;
   localparam int TAP_IDX_W   = 3;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int PIX_W       = 8;
   localparam int WEIGHT_W    = 2 * TAP_W;
   localparam int PROD_W      = PIX_W + WEIGHT_W;
   localparam int ACC_W       = PROD_W + 8;
   localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd1024;
   localparam logic [CFG_H_W-1:0] HEIGHT_RST = 12'd1024;
   localparam logic [TAP_W-1:0]   TAP0_RST   = 16'hFFFF;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_TAP_CENTER   = 3'd2,
      CSR_TAP_OFF1     = 3'd3,
      CSR_TAP_OFF2     = 3'd4,
      CSR_TAP_OFF3     = 3'd5,
      CSR_TAP_OFF4     = 3'd6
   } csr_index_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // request and response payloads
   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             flush;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_end;
   } rsp_payload_type;

endpackage

FILE: rtl/gbw_store.sv
// line store: single write port, registered single read port
`timescale 1ns / 1ps
module gbw_store #(
   parameter int DEPTH  = 8 * gbw_pkg::MAX_WIDTH_DEF + 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [gbw_pkg::PIX_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [gbw_pkg::PIX_W-1:0] rd_data
);

   logic [gbw_pkg::PIX_W-1:0] mem [DEPTH];
   logic [gbw_pkg::PIX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gaussian_blur_window_filter.sv
// top level of the streaming gaussian window blur
`timescale 1ns / 1ps
// Streaming KERNEL_SIZE x KERNEL_SIZE Gaussian blur over an 8-bit raster frame.
// Each request carries one pixel (or a flush that drains the last rows); the
// pixel goes into a circular line store of 8*MAX_WIDTH+16 bytes, and once
// KERNEL_SIZE/2 rows plus KERNEL_SIZE/2 pixels have arrived each request
// yields one blurred pixel. The window is gathered from the line store one
// neighbor per cycle through its single read port, so a request that yields
// a pixel holds req_ready low until its sum goes to the output register, and
// one that yields none leaves it high. Frame size is latched at the first
// pixel of each frame; tap weights are read live, so write them between frames.
module gaussian_blur_window_filter #(
   parameter int MAX_WIDTH   = gbw_pkg::MAX_WIDTH_DEF,
   parameter int KERNEL_SIZE = gbw_pkg::KERNEL_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  gbw_pkg::req_payload_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output gbw_pkg::rsp_payload_type         rsp_data,
   input  logic                             csr_we,
   input  logic [gbw_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [gbw_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int HALF    = KERNEL_SIZE / 2;
   localparam int DEPTH   = 8 * MAX_WIDTH + 16;
   localparam int A_W     = $clog2(DEPTH);
   localparam int FW_W    = $clog2(MAX_WIDTH + 1);
   localparam int FH_W    = gbw_pkg::CFG_H_W;
   localparam int LIN_W   = FW_W + FH_W;
   localparam int K_W     = $clog2(KERNEL_SIZE);
   localparam int RS_W    = FH_W + 1;
   localparam int CS_W    = FW_W + 1;
   localparam int AX_W    = A_W + 2;

   // configuration registers
   logic [gbw_pkg::CFG_W_W-1:0] cfg_width_ff;
   logic [gbw_pkg::CFG_H_W-1:0] cfg_height_ff;
   logic [gbw_pkg::TAP_W-1:0]   tap_ff [gbw_pkg::NUM_TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= gbw_pkg::WIDTH_RST;
         cfg_height_ff <= gbw_pkg::HEIGHT_RST;
         tap_ff[0]     <= gbw_pkg::TAP0_RST;
         tap_ff[1]     <= '0;
         tap_ff[2]     <= '0;
         tap_ff[3]     <= '0;
         tap_ff[4]     <= '0;
      end else if (csr_we) begin
         case (gbw_pkg::csr_index_type'(csr_addr))
            gbw_pkg::CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_wdata[gbw_pkg::CFG_W_W-1:0];
            gbw_pkg::CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_wdata[gbw_pkg::CFG_H_W-1:0];
            gbw_pkg::CSR_TAP_CENTER:   tap_ff[0]     <= csr_wdata;
            gbw_pkg::CSR_TAP_OFF1:     tap_ff[1]     <= csr_wdata;
            gbw_pkg::CSR_TAP_OFF2:     tap_ff[2]     <= csr_wdata;
            gbw_pkg::CSR_TAP_OFF3:     tap_ff[3]     <= csr_wdata;
            gbw_pkg::CSR_TAP_OFF4:     tap_ff[4]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame and stream position state
   gbw_pkg::state_type state_ff, state_in;
   logic [FW_W-1:0]  fw_ff;
   logic [FH_W-1:0]  fh_ff;
   logic [LIN_W-1:0] total_ff, lag_ff;
   logic [LIN_W-1:0] in_lin_ff, out_lin_ff;
   logic [A_W-1:0]   wr_addr_ff, out_base_ff;
   logic [FH_W-1:0]  out_row_ff;
   logic [FW_W-1:0]  out_col_ff;

   // window scan state
   logic [FH_W-1:0]  sc_row_ff;
   logic [FW_W-1:0]  sc_col_ff;
   logic             sc_end_ff;
   logic [A_W-1:0]   row_start_ff;
   logic [K_W-1:0]   ri_ff, cj_ff;
   logic             drain_ff;
   logic             v1_ff, v2_ff;
   logic [gbw_pkg::WEIGHT_W-1:0] w_ff;
   logic [gbw_pkg::PROD_W-1:0]   prod_ff;
   logic [gbw_pkg::ACC_W-1:0]    acc_ff;
   logic             rsp_valid_ff;
   gbw_pkg::rsp_payload_type rsp_data_ff;

   // request decode
   logic             req_fire, start, in_frame, keep, produce, last_out, store_we;
   logic [FW_W-1:0]  clamp_w;
   logic [FH_W-1:0]  clamp_h;
   logic [A_W-1:0]   wr_next, base_next, start_addr;
   logic [AX_W-1:0]  start_tmp;

   assign req_ready = (state_ff == gbw_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign start     = (in_lin_ff == '0);
   assign in_frame  = in_lin_ff < total_ff;
   assign keep      = req_fire && !(req_data.flush && (start || in_frame));
   assign store_we  = req_fire && !req_data.flush && (start || in_frame);
   assign produce   = keep && !start && (in_lin_ff >= lag_ff);
   assign last_out  = (out_lin_ff + LIN_W'(1)) == total_ff;

   // clamp the frame size registers
   always_comb begin
      if (cfg_width_ff == '0) begin
         clamp_w = FW_W'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         clamp_w = FW_W'(MAX_WIDTH);
      end else begin
         clamp_w = FW_W'(cfg_width_ff);
      end
      clamp_h = (cfg_height_ff == '0) ? FH_W'(1) : cfg_height_ff;
   end

   // circular address steps
   assign wr_next   = (32'(wr_addr_ff) == DEPTH - 1) ? '0 : wr_addr_ff + A_W'(1);
   assign base_next = (32'(out_base_ff) == DEPTH - 1) ? '0 : out_base_ff + A_W'(1);
   assign start_tmp = AX_W'(out_base_ff) + AX_W'(DEPTH) - AX_W'(lag_ff);
   assign start_addr = (start_tmp >= AX_W'(DEPTH)) ? A_W'(start_tmp - AX_W'(DEPTH))
                                                   : A_W'(start_tmp);

   // stream position bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         in_lin_ff   <= '0;
         out_lin_ff  <= '0;
         wr_addr_ff  <= '0;
         out_base_ff <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         fw_ff       <= FW_W'(MAX_WIDTH);
         fh_ff       <= FH_W'(1024);
         total_ff    <= '0;
         lag_ff      <= '0;
      end else if (keep) begin
         if (start) begin
            fw_ff    <= clamp_w;
            fh_ff    <= clamp_h;
            total_ff <= LIN_W'(clamp_w) * LIN_W'(clamp_h);
            lag_ff   <= LIN_W'(HALF) * LIN_W'(clamp_w) + LIN_W'(HALF);
         end
         if (produce && last_out) begin
            in_lin_ff   <= '0;
            out_lin_ff  <= '0;
            wr_addr_ff  <= '0;
            out_base_ff <= '0;
            out_row_ff  <= '0;
            out_col_ff  <= '0;
         end else begin
            in_lin_ff  <= in_lin_ff + LIN_W'(1);
            wr_addr_ff <= wr_next;
            if (produce) begin
               out_lin_ff  <= out_lin_ff + LIN_W'(1);
               out_base_ff <= base_next;
               if (out_col_ff + FW_W'(1) >= fw_ff) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + FH_W'(1);
               end else begin
                  out_col_ff <= out_col_ff + FW_W'(1);
               end
            end
         end
      end
   end

   // window neighbor address and bounds
   logic [AX_W-1:0]  rd_tmp, rs_tmp;
   logic [A_W-1:0]   rd_addr, row_next;
   logic [RS_W-1:0]  rr_sum;
   logic [CS_W-1:0]  cc_sum;
   logic             nb_ok, scan_last;
   logic [K_W-1:0]   ti, tj;
   logic [gbw_pkg::PIX_W-1:0] rd_data;

   assign rd_tmp   = AX_W'(row_start_ff) + AX_W'(cj_ff);
   assign rd_addr  = (rd_tmp >= AX_W'(DEPTH)) ? A_W'(rd_tmp - AX_W'(DEPTH)) : A_W'(rd_tmp);
   assign rs_tmp   = AX_W'(row_start_ff) + AX_W'(fw_ff);
   assign row_next = (rs_tmp >= AX_W'(DEPTH)) ? A_W'(rs_tmp - AX_W'(DEPTH)) : A_W'(rs_tmp);
   assign rr_sum   = RS_W'(sc_row_ff) + RS_W'(ri_ff);
   assign cc_sum   = CS_W'(sc_col_ff) + CS_W'(cj_ff);
   assign nb_ok    = (rr_sum >= RS_W'(HALF)) && (rr_sum < RS_W'(fh_ff) + RS_W'(HALF))
                  && (cc_sum >= CS_W'(HALF)) && (cc_sum < CS_W'(fw_ff) + CS_W'(HALF));
   assign ti       = (ri_ff >= K_W'(HALF)) ? ri_ff - K_W'(HALF) : K_W'(HALF) - ri_ff;
   assign tj       = (cj_ff >= K_W'(HALF)) ? cj_ff - K_W'(HALF) : K_W'(HALF) - cj_ff;
   assign scan_last = (ri_ff == K_W'(KERNEL_SIZE - 1)) && (cj_ff == K_W'(KERNEL_SIZE - 1));

   gbw_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (A_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (wr_addr_ff),
      .wr_data (req_data.pixel_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gbw_pkg::ST_IDLE: begin
            if (produce) state_in = gbw_pkg::ST_SCAN;
         end
         gbw_pkg::ST_SCAN: begin
            if (scan_last) state_in = gbw_pkg::ST_DRAIN;
         end
         gbw_pkg::ST_DRAIN: begin
            if (drain_ff) state_in = gbw_pkg::ST_DONE;
         end
         gbw_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = gbw_pkg::ST_IDLE;
         end
         default: state_in = gbw_pkg::ST_IDLE;
      endcase
   end

   // scan counters, drain flag and pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         ri_ff    <= '0;
         cj_ff    <= '0;
         drain_ff <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         v1_ff <= (state_ff == gbw_pkg::ST_SCAN);
         v2_ff <= v1_ff;
         if (produce) begin
            ri_ff    <= '0;
            cj_ff    <= '0;
            drain_ff <= 1'b0;
         end else if (state_ff == gbw_pkg::ST_SCAN) begin
            if (cj_ff == K_W'(KERNEL_SIZE - 1)) begin
               cj_ff <= '0;
               ri_ff <= ri_ff + K_W'(1);
            end else begin
               cj_ff <= cj_ff + K_W'(1);
            end
         end else if (state_ff == gbw_pkg::ST_DRAIN) begin
            drain_ff <= 1'b1;
         end
      end
   end

   // payload side of the scan: snapshot, weights, products, accumulator
   always_ff @(posedge clock) begin
      if (produce) begin
         sc_row_ff    <= out_row_ff;
         sc_col_ff    <= out_col_ff;
         sc_end_ff    <= last_out;
         row_start_ff <= start_addr;
         acc_ff       <= '0;
      end else begin
         if (state_ff == gbw_pkg::ST_SCAN && cj_ff == K_W'(KERNEL_SIZE - 1)) begin
            row_start_ff <= row_next;
         end
         if (v2_ff) begin
            acc_ff <= acc_ff + gbw_pkg::ACC_W'(prod_ff);
         end
      end
      w_ff    <= nb_ok ? tap_ff[gbw_pkg::TAP_IDX_W'(ti)] * tap_ff[gbw_pkg::TAP_IDX_W'(tj)]
                       : '0;
      // zero weight gives zero, whatever the store returns off the frame
      prod_ff <= (w_ff == '0) ? '0
                              : gbw_pkg::PROD_W'(rd_data) * gbw_pkg::PROD_W'(w_ff);
   end

   // output register, saturate the truncated sum
   logic load_rsp;
   assign load_rsp = (state_ff == gbw_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff.pixel_out <= (acc_ff[gbw_pkg::ACC_W-1:32] > 16'd255)
                                  ? 8'hFF : acc_ff[39:32];
         rsp_data_ff.frame_end <= sc_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
